// ----- rtl/htb_pkg.sv -----
package htb_pkg;

  // Default depth of the byte store that indexes count into
  localparam int DEF_MAX_BYTES = 256;

  // Result codes
  typedef enum logic [2:0] {
    ST_BYTE     = 3'd0,
    ST_END_OK   = 3'd1,
    ST_BAD_CHAR = 3'd2,
    ST_ODD      = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  // One result beat
  typedef struct packed {
    logic [7:0] byte_value;
    logic [7:0] byte_index;
    status_t    status;
  } htb_result_t;

  // Handoff from the input register to the decode stage
  typedef struct packed {
    logic       valid;
    logic [7:0] character;
  } htb_char_t;

endpackage

// ----- rtl/htb_in_stage.sv -----
module htb_in_stage
  import htb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] character,
  input  logic       take,
  output htb_char_t  held
);

  logic       hold_valid;
  logic [7:0] hold_char;
  logic       accept;

  // Hold a beat until the decode stage takes it
  assign in_stall = hold_valid && !take;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (take) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_char <= character;
    end
  end

  assign held.valid     = hold_valid;
  assign held.character = hold_char;

endmodule

// ----- rtl/htb_decode.sv -----
module htb_decode
  import htb_pkg::*;
#(
  parameter int MAX_BYTES = DEF_MAX_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  htb_char_t   held,
  output logic        take,
  output logic        out_valid,
  input  logic        out_stall,
  output htb_result_t result
);

  localparam int IDX_W = $clog2(MAX_BYTES + 1);

  logic             have_high_digit;
  logic [3:0]       high_digit;
  logic [IDX_W-1:0] next_index;
  logic             discarding;

  logic             have_high_digit_next;
  logic [3:0]       high_digit_next;
  logic [IDX_W-1:0] next_index_next;
  logic             discarding_next;

  logic             emit;
  htb_result_t      result_next;
  logic [7:0]       c;
  logic             is_nul;
  logic             is_blank;
  logic             is_hex;
  logic [3:0]       digit;
  logic [IDX_W+7:0] index_wide;

  // Classify the character
  always_comb begin
    c        = held.character;
    is_nul   = (c == 8'h00);
    is_blank = ((c >= 8'd9) && (c <= 8'd13)) || (c == 8'd32);
    is_hex   = 1'b1;
    digit    = 4'd0;
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      digit = c[3:0];
    end else if (((c >= 8'h41) && (c <= 8'h46)) || ((c >= 8'h61) && (c <= 8'h66))) begin
      digit = c[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
  end

  assign index_wide = {8'd0, next_index};

  // Advance when the result register is free
  assign take = held.valid && (!out_valid || !out_stall);

  // Next pairing state and result
  always_comb begin
    have_high_digit_next = have_high_digit;
    high_digit_next      = high_digit;
    next_index_next      = next_index;
    discarding_next      = discarding;
    emit                 = 1'b0;
    result_next          = '{byte_value: 8'd0, byte_index: 8'd0, status: ST_BYTE};
    if (discarding) begin
      if (is_nul) begin
        discarding_next      = 1'b0;
        have_high_digit_next = 1'b0;
        high_digit_next      = 4'd0;
        next_index_next      = '0;
      end
    end else if (is_nul) begin
      emit                 = 1'b1;
      result_next.status   = have_high_digit ? ST_ODD : ST_END_OK;
      have_high_digit_next = 1'b0;
      high_digit_next      = 4'd0;
      next_index_next      = '0;
    end else if (is_blank) begin
      emit = 1'b0;
    end else if (!is_hex) begin
      emit                 = 1'b1;
      result_next.status   = ST_BAD_CHAR;
      have_high_digit_next = 1'b0;
      high_digit_next      = 4'd0;
      next_index_next      = '0;
      discarding_next      = 1'b1;
    end else if (!have_high_digit) begin
      have_high_digit_next = 1'b1;
      high_digit_next      = digit;
    end else if (next_index == IDX_W'(MAX_BYTES)) begin
      emit                 = 1'b1;
      result_next.status   = ST_OVERFLOW;
      have_high_digit_next = 1'b0;
      high_digit_next      = 4'd0;
      next_index_next      = '0;
      discarding_next      = 1'b1;
    end else begin
      emit                   = 1'b1;
      result_next.byte_value = {high_digit, digit};
      result_next.byte_index = index_wide[7:0];
      have_high_digit_next   = 1'b0;
      high_digit_next        = 4'd0;
      next_index_next        = next_index + IDX_W'(1);
    end
  end

  // State update on each taken beat
  always_ff @(posedge clk) begin
    if (rst) begin
      have_high_digit <= 1'b0;
      high_digit      <= 4'd0;
      next_index      <= '0;
      discarding      <= 1'b0;
    end else if (take) begin
      have_high_digit <= have_high_digit_next;
      high_digit      <= high_digit_next;
      next_index      <= next_index_next;
      discarding      <= discarding_next;
    end
  end

  // Result register: load on emit, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (take && emit) || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      result <= result_next;
    end
  end

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    next_index <= IDX_W'(MAX_BYTES))
    else $error("byte index counter passed the store size");

  a_no_byte_when_discarding: assert property (@(posedge clk) disable iff (rst)
    take && emit && (result_next.status == ST_BYTE) |-> !discarding)
    else $error("byte decoded while discarding");

  a_error_sets_discard: assert property (@(posedge clk) disable iff (rst)
    take && emit && ((result_next.status == ST_BAD_CHAR) ||
      (result_next.status == ST_OVERFLOW)) |=> discarding)
    else $error("error reported without entering discard");

  a_status_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result.status != ST_BYTE) |->
      (result.byte_value == 8'd0) && (result.byte_index == 8'd0))
    else $error("non-byte result carries data");

endmodule

// ----- rtl/hex_text_to_bytes_parser.sv -----
// Hex text to bytes parser. Takes one ASCII character per beat from a
// NUL-terminated string, skips whitespace, and pairs hex digits (either case)
// into bytes, each given with its index in the byte store. A NUL ends the
// string with status 1, or status 3 if a lone digit is waiting. A non-hex
// character gives status 2, and a pair beyond MAX_BYTES gives status 4; after
// either, characters are dropped up to and including the next NUL. Whitespace
// and first digits give no result beat. One character is accepted every
// cycle unless the input stalls; a character flows from the input register
// through one stage of decode logic into the result register. A stalled
// result holds the input register, and the input stalls only once that
// register is full as well.
module hex_text_to_bytes_parser
  import htb_pkg::*;
#(
  parameter int MAX_BYTES = DEF_MAX_BYTES
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] character,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] byte_value,
  output logic [7:0] byte_index,
  output logic [2:0] status
);

  htb_char_t   held;
  logic        take;
  htb_result_t result;

  htb_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .character (character),
    .take      (take),
    .held      (held)
  );

  htb_decode #(
    .MAX_BYTES (MAX_BYTES)
  ) u_decode (
    .clk       (clk),
    .rst       (rst),
    .held      (held),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result)
  );

  assign byte_value = result.byte_value;
  assign byte_index = result.byte_index;
  assign status     = result.status;

endmodule
